@@ hdl/edfs_pkg.sv @@
// Shared types and constants of the EDF periodic task scheduler.
// Used by edfs_front, edfs_back and edf_periodic_task_scheduler_core.
// No dependencies.
package edfs_pkg;

    // Table size and time width
    localparam int TASKS     = 8;
    localparam int TIME_BITS = 32;

    // Fixed field widths of the item and result words
    localparam int OP_W     = 2;
    localparam int PERIOD_W = 32;
    localparam int NOW_W    = 32;
    localparam int SEL_W    = 4;
    localparam int MISS_W   = 8;

    // Slot index width
    localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [SEL_W-1:0]     t_sel;

    // Operation codes as they arrive on the op field
    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_END    = 2'd1,
        OP_SCHED  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Task life-cycle codes
    typedef enum logic [2:0] {
        ST_UNUSED    = 3'd0,
        ST_DEFINED   = 3'd1,
        ST_READY     = 3'd2,
        ST_RUNNING   = 3'd3,
        ST_PREEMPTED = 3'd4,
        ST_ENDED     = 3'd5,
        ST_FAILED    = 3'd6
    } t_task_st;

    // Classified command word from front to back
    typedef struct packed {
        logic                valid;
        t_op                 op;
        logic [PERIOD_W-1:0] period;
        t_time               now;
    } t_cmd;

    // Result word
    typedef struct packed {
        logic              ok;
        t_sel              slot;
        t_sel              selected;
        logic [MISS_W-1:0] missed;
    } t_res;

endpackage

@@ hdl/edfs_front.sv @@
// Front end of the EDF scheduler: accepts input words, decodes the op
// and buffers classified commands in a two-entry queue for the back end.
// Depends on edfs_pkg.
module edfs_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [edfs_pkg::OP_W-1:0]     i_op,
    input  logic [edfs_pkg::PERIOD_W-1:0] i_period,
    input  logic [edfs_pkg::NOW_W-1:0]    i_now,
    output edfs_pkg::t_cmd               o_cmd,
    input  logic                         i_cmd_pop
);
    import edfs_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_op        n_op;
    t_cmd       n_word;
    logic       push_ok;
    logic       pop_ok;

    // Decode the raw op; the spare code becomes a no-op
    always_comb begin
        unique case (i_op)
            OP_CREATE: n_op = OP_CREATE;
            OP_END:    n_op = OP_END;
            OP_SCHED:  n_op = OP_SCHED;
            default:   n_op = OP_NONE;
        endcase
    end

    always_comb begin
        n_word.valid  = 1'b1;
        n_word.op     = n_op;
        n_word.period = i_period;
        n_word.now    = TIME_BITS'(i_now);
    end

    assign o_full  = (r_count == 2'd2);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_cmd_pop && (r_count != 2'd0);

    // Present the oldest word
    always_comb begin
        o_cmd       = r_q[r_rd_ptr];
        o_cmd.valid = (r_count != 2'd0);
    end

    // Hold the queue and its pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_q[r_wr_ptr] <= n_word;
                r_wr_ptr      <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 2'd1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

@@ hdl/edfs_back.sv @@
// Back end of the EDF scheduler: task table, command sequencer with a
// one-slot-per-cycle scheduling scan, and the result register.
// Depends on edfs_pkg.
module edfs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  edfs_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output edfs_pkg::t_res o_res,
    output logic           o_res_valid,
    input  logic           i_res_pop
);
    import edfs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PICK
    } t_state;

    // Task table
    t_task_st            r_st  [TASKS];
    t_time               r_rt  [TASKS];
    t_time               r_dl  [TASKS];
    logic [PERIOD_W-1:0] r_per [TASKS];
    t_sel                r_run;

    // Sequencer and scan registers
    t_state              r_state;
    t_idx                r_idx;
    t_time               r_now;
    logic                r_have;
    t_idx                r_best;
    t_time               r_best_dl;
    logic [PERIOD_W-1:0] r_best_per;
    logic [MISS_W-1:0]   r_missed;
    t_res                r_res;
    logic                r_res_valid;

    logic                res_free;
    logic                res_load;
    logic                free_found;
    t_idx                free_idx;

    t_task_st            cur_st;
    t_time               cur_dl;
    logic [PERIOD_W-1:0] cur_per;
    logic                used;
    logic                ended;
    t_time               s_rt;
    t_time               s_dl;
    t_task_st            s0;
    t_task_st            s1;
    t_task_st            s2;
    t_task_st            s3;
    logic                miss;
    logic                cand;
    logic                better;
    logic [MISS_W-1:0]   miss_bit;

    assign res_free    = !r_res_valid || i_res_pop;
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    // Take a command when it can be carried out now
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd.valid &&
                       ((i_cmd.op == OP_SCHED) || res_free);

    // A result word is written by every finished command
    assign res_load = ((r_state == S_IDLE) && o_cmd_pop && (i_cmd.op != OP_SCHED)) ||
                      ((r_state == S_PICK) && res_free);

    // Find the lowest unused or ended slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < TASKS; i++) begin
            if (!free_found && ((r_st[i] == ST_UNUSED) || (r_st[i] == ST_ENDED))) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Evaluate the slot under the scan pointer
    always_comb begin
        cur_st  = r_st[r_idx];
        cur_dl  = r_dl[r_idx];
        cur_per = r_per[r_idx];
        used    = (cur_st != ST_UNUSED);
        ended   = (cur_st == ST_ENDED);
        // renew an ended task for its next period
        s_rt    = ended ? cur_dl : r_rt[r_idx];
        s_dl    = ended ? (cur_dl + TIME_BITS'(cur_per)) : cur_dl;
        s0      = ended ? ST_DEFINED : cur_st;
        // release when due
        s1      = (((s0 == ST_DEFINED) || (s0 == ST_FAILED)) && (s_rt <= r_now)) ?
                  ST_READY : s0;
        // deadline miss
        miss    = (s_dl < r_now);
        s2      = miss ? ST_FAILED : s1;
        // preempt the running task
        s3      = (s2 == ST_RUNNING) ? ST_PREEMPTED : s2;
        cand    = used && ((s3 == ST_READY) || (s3 == ST_PREEMPTED));
        better  = !r_have || (s_dl < r_best_dl) ||
                  ((s_dl == r_best_dl) && (cur_per < r_best_per));
        miss_bit = MISS_W'(1) << r_idx;
    end

    // Sequencer, table and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_run       <= SEL_W'(TASKS);
            for (int i = 0; i < TASKS; i++) begin
                r_st[i] <= ST_UNUSED;
            end
        end else begin
            // load a new result word, or drop the one just popped
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        unique case (i_cmd.op)
                            OP_CREATE: begin
                                if (free_found) begin
                                    r_per[free_idx] <= i_cmd.period;
                                    r_rt[free_idx]  <= '0;
                                    r_dl[free_idx]  <= TIME_BITS'(i_cmd.period);
                                    r_st[free_idx]  <= ST_DEFINED;
                                end
                                r_res.ok       <= free_found;
                                r_res.slot     <= free_found ? SEL_W'(free_idx) :
                                                  SEL_W'(TASKS);
                                r_res.selected <= r_run;
                                r_res.missed   <= '0;
                            end
                            OP_END: begin
                                if (r_run < SEL_W'(TASKS)) begin
                                    r_st[r_run[IDX_W-1:0]] <= ST_ENDED;
                                end
                                r_res.ok       <= 1'b1;
                                r_res.slot     <= SEL_W'(TASKS);
                                r_res.selected <= r_run;
                                r_res.missed   <= '0;
                            end
                            OP_SCHED: begin
                                r_now    <= i_cmd.now;
                                r_idx    <= '0;
                                r_have   <= 1'b0;
                                r_missed <= '0;
                                r_state  <= S_SCAN;
                            end
                            OP_NONE: begin
                                r_res.ok       <= 1'b0;
                                r_res.slot     <= SEL_W'(TASKS);
                                r_res.selected <= r_run;
                                r_res.missed   <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (used) begin
                        r_st[r_idx] <= s3;
                        r_rt[r_idx] <= s_rt;
                        r_dl[r_idx] <= s_dl;
                        if (miss) begin
                            r_missed <= r_missed | miss_bit;
                        end
                        if (cand && better) begin
                            r_have     <= 1'b1;
                            r_best     <= r_idx;
                            r_best_dl  <= s_dl;
                            r_best_per <= cur_per;
                        end
                    end
                    if (r_idx == IDX_W'(TASKS - 1)) begin
                        r_state <= S_PICK;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_PICK: begin
                    // commit the winner once the result register is free
                    if (res_free) begin
                        if (r_have) begin
                            r_st[r_best] <= ST_RUNNING;
                        end
                        r_run          <= r_have ? SEL_W'(r_best) : SEL_W'(TASKS);
                        r_res.ok       <= 1'b1;
                        r_res.slot     <= SEL_W'(TASKS);
                        r_res.selected <= r_have ? SEL_W'(r_best) : SEL_W'(TASKS);
                        r_res.missed   <= r_missed;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/edf_periodic_task_scheduler_core.sv @@
// Top level of the EDF periodic task scheduler.
// Instantiates edfs_front and edfs_back; depends on edfs_pkg.
//
// Earliest-deadline-first scheduler over a table of eight periodic tasks.
// Words are pushed like into a queue (push/full) and one result per word is
// popped like from a queue (empty/pop), oldest first. op 0 creates a task in
// the lowest unused or ended slot, op 1 ends the running task, op 2 runs a
// scheduling pass at time now, op 3 does nothing. A create, end or no-op word
// reaches the result register once the back end is idle and the result
// register is free. A schedule word loads its time, scans the table one slot
// a cycle through a single port, and commits the winner once the result
// register is free. The front queue holds two words, so input is taken while
// the back end works and while a result waits to be popped.
module edf_periodic_task_scheduler_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [edfs_pkg::OP_W-1:0]     i_op,
    input  logic [edfs_pkg::PERIOD_W-1:0] i_period,
    input  logic [edfs_pkg::NOW_W-1:0]    i_now,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_ok,
    output logic [edfs_pkg::SEL_W-1:0]    o_slot,
    output logic [edfs_pkg::SEL_W-1:0]    o_selected,
    output logic                          o_idle,
    output logic [edfs_pkg::MISS_W-1:0]   o_missed_mask
);
    import edfs_pkg::*;

    t_cmd cmd;
    logic cmd_pop;
    t_res res;
    logic res_valid;

    // Accept and classify
    edfs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_op      (i_op),
        .i_period  (i_period),
        .i_now     (i_now),
        .o_cmd     (cmd),
        .i_cmd_pop (cmd_pop)
    );

    // Carry out
    edfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_pop   (pop)
    );

    // Drive the result ports
    assign empty         = !res_valid;
    assign o_ok          = res.ok;
    assign o_slot        = res.slot;
    assign o_selected    = res.selected;
    assign o_idle        = (res.selected == SEL_W'(TASKS));
    assign o_missed_mask = res.missed;

endmodule
